>>> hw/rtl/mmau_pkg.sv
// Shared types, coefficients and the loggy table for the activation unit.
package mmau_pkg;

   // Activation functions selected by the mode register.
   typedef enum logic [2:0] {
      MODE_LINEAR  = 3'd0,
      MODE_LEAKY   = 3'd1,
      MODE_RAMP    = 3'd2,
      MODE_LOGGY   = 3'd3,
      MODE_PLSE    = 3'd4,
      MODE_STAIR   = 3'd5,
      MODE_HARDTAN = 3'd6,
      MODE_LHTAN   = 3'd7
   } mode_type;

   // How the last stage builds the result.
   typedef enum logic [1:0] {
      SEL_MUL,
      SEL_ALT,
      SEL_LOG
   } sel_type;

   // Register indexes of the configuration port.
   localparam int unsigned REG_MODE = 0;

   // Constant coefficients, unsigned Q0.16.
   localparam int          K_SHIFT = 16;
   localparam logic [15:0] K_001   = 16'd655;
   localparam logic [15:0] K_01    = 16'd6554;
   localparam logic [15:0] K_0001  = 16'd66;
   localparam logic [15:0] K_0125  = 16'd8192;

   // tanh(x/2) at steps of 0.5 over [0,13], unsigned Q1.16.
   localparam int          LOG_POINTS = 27;
   localparam logic [16:0] LOG_ONE    = 17'd65536;
   localparam logic [16:0] LOG_TAB [0:LOG_POINTS-1] = '{
      17'd0,     17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593, 17'd59320,
      17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65003, 17'd65212, 17'd65339,
      17'd65417, 17'd65464, 17'd65492, 17'd65509, 17'd65520, 17'd65526, 17'd65530,
      17'd65532, 17'd65534, 17'd65535, 17'd65535, 17'd65536, 17'd65536
   };

endpackage

>>> hw/rtl/mmau_pipe.sv
// Four-stage activation datapath: input register, operand prep, multiply, finish.
module mmau_pipe #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  mmau_pkg::mode_type mode,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample_out,
   output logic               rsp_saturated
);
   import mmau_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int OW  = ((W > F + 3) ? W : F + 3) + 2;
   localparam int RW  = OW + 2;
   localparam int PW  = OW + K_SHIFT;
   localparam int LPW = 17 + F - 1;

   localparam logic signed [OW-1:0] ONE  = OW'(1) << F;
   localparam logic signed [OW-1:0] FOUR = OW'(1) << (F + 2);
   localparam logic signed [OW-1:0] HALF = OW'(1) << (F - 1);
   localparam logic signed [RW-1:0] HI   = RW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic signed [RW-1:0] LO   = -RW'(64'd1 << (W - 1));

   // Stage handshake: a stage moves when it is empty or its successor moves.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: capture the low DATA_WIDTH bits of the input transaction.
   logic [63:0]         in_ext;
   logic signed [W-1:0] x1_ff;

   assign in_ext = {32'd0, req_sample_in};

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) x1_ff <= in_ext[W-1:0];
   end

   // Stage 2 logic: choose the multiply operand, coefficient and offset.
   logic signed [OW-1:0] xe, op, base, alt, stair_v;
   logic [15:0]          coef;
   sel_type              sel;
   logic [OW-1:0]        op_mag, lm, idx;
   logic                 nodd, lfar;
   logic [4:0]           li;
   logic [16:0]          la, lb;

   assign xe = OW'(x1_ff);

   // Stair: floor(x/2) with the fraction of x kept when floor(x) is odd.
   always_comb begin
      logic signed [OW-1:0] nsh;
      logic signed [OW-1:0] hsh;
      nsh     = xe >>> F;
      hsh     = xe >>> (F + 1);
      nodd    = nsh[0];
      stair_v = (hsh <<< F) | (nodd ? OW'(xe[F-1:0]) : OW'(0));
   end

   always_comb begin
      sel  = SEL_ALT;
      op   = xe;
      coef = K_001;
      base = '0;
      alt  = xe;
      case (mode)
         MODE_LINEAR: begin
            alt = xe;
         end
         MODE_LEAKY: begin
            if (xe <= 0) sel = SEL_MUL;
         end
         MODE_RAMP: begin
            sel  = SEL_MUL;
            coef = K_01;
            base = (xe > 0) ? xe : OW'(0);
         end
         MODE_LOGGY: begin
            sel = SEL_LOG;
         end
         MODE_PLSE: begin
            sel = SEL_MUL;
            if (xe < -FOUR) begin
               op = xe + FOUR;
            end else if (xe > FOUR) begin
               op   = xe - FOUR;
               base = ONE;
            end else begin
               coef = K_0125;
               base = HALF;
            end
         end
         MODE_STAIR: begin
            alt = stair_v;
         end
         MODE_HARDTAN: begin
            if (xe < -ONE)     alt = -ONE;
            else if (xe > ONE) alt = ONE;
         end
         MODE_LHTAN: begin
            coef = K_0001;
            if (xe < 0) begin
               sel = SEL_MUL;
            end else if (xe > ONE) begin
               sel  = SEL_MUL;
               op   = xe - ONE;
               base = ONE;
            end
         end
         default: begin
            alt = xe;
         end
      endcase
   end

   assign op_mag = (op < 0) ? OW'(-op) : OW'(op);

   // Loggy: table segment from the magnitude, half a unit per step.
   assign lm   = (xe < 0) ? OW'(-xe) : OW'(xe);
   assign idx  = lm >> (F - 1);
   assign lfar = idx >= OW'(LOG_POINTS - 1);
   assign li   = lfar ? 5'd0 : idx[4:0];
   assign la   = LOG_TAB[li];
   assign lb   = LOG_TAB[li + 5'd1];

   logic [OW-1:0]        mag2_ff;
   logic                 neg2_ff, lneg2_ff, lfar2_ff;
   logic [15:0]          coef2_ff;
   logic signed [OW-1:0] base2_ff, alt2_ff;
   sel_type              sel2_ff;
   logic [16:0]          la2_ff, ld2_ff;
   logic [F-2:0]         lfr2_ff;

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         mag2_ff  <= op_mag;
         neg2_ff  <= op < 0;
         coef2_ff <= coef;
         base2_ff <= base;
         alt2_ff  <= alt;
         sel2_ff  <= sel;
         la2_ff   <= la;
         ld2_ff   <= lb - la;
         lfr2_ff  <= lm[F-2:0];
         lneg2_ff <= xe < 0;
         lfar2_ff <= lfar;
      end
   end

   // Stage 3: the two multiplies.
   logic [PW-1:0]        prod3_ff;
   logic [LPW-1:0]       lprod3_ff;
   logic                 neg3_ff, lneg3_ff, lfar3_ff;
   logic signed [OW-1:0] base3_ff, alt3_ff;
   sel_type              sel3_ff;
   logic [16:0]          la3_ff;

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         prod3_ff  <= PW'(mag2_ff) * PW'(coef2_ff);
         lprod3_ff <= LPW'(ld2_ff) * LPW'(lfr2_ff);
         neg3_ff   <= neg2_ff;
         lneg3_ff  <= lneg2_ff;
         lfar3_ff  <= lfar2_ff;
         base3_ff  <= base2_ff;
         alt3_ff   <= alt2_ff;
         sel3_ff   <= sel2_ff;
         la3_ff    <= la2_ff;
      end
   end

   // Stage 4 logic: round, apply sign and offset, interpolate, clamp.
   logic [PW-1:0]        prod_rnd;
   logic [OW-1:0]        mres_mag;
   logic signed [RW-1:0] mres, lres, r;
   logic [LPW:0]         lrnd;
   logic [17:0]          v;
   logic [RW-1:0]        vs;
   logic                 sat;
   logic signed [W-1:0]  rc;

   assign prod_rnd = prod3_ff + (PW'(1) << (K_SHIFT - 1));
   assign mres_mag = prod_rnd[PW-1:K_SHIFT];
   assign mres     = (neg3_ff ? -RW'(mres_mag) : RW'(mres_mag)) + RW'(base3_ff);

   assign lrnd = (LPW + 1)'(lprod3_ff) + ((LPW + 1)'(1) << (F - 2));
   assign v    = lfar3_ff ? 18'(LOG_ONE) : 18'(la3_ff) + 18'(lrnd >> (F - 1));

   generate
      if (F >= 16) begin : g_up
         assign vs = RW'(v) << (F - 16);
      end else begin : g_down
         assign vs = RW'((v + (18'd1 << (15 - F))) >> (16 - F));
      end
   endgenerate

   assign lres = lneg3_ff ? -vs : vs;

   always_comb begin
      case (sel3_ff)
         SEL_MUL: r = mres;
         SEL_LOG: r = lres;
         default: r = RW'(alt3_ff);
      endcase
      sat = 1'b0;
      if (r > HI) begin
         r   = HI;
         sat = 1'b1;
      end else if (r < LO) begin
         r   = LO;
         sat = 1'b1;
      end
      rc = r[W-1:0];
   end

   // Output register: holds the result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (adv4 && v3_ff) begin
         rsp_sample_out <= 32'(rc);
         rsp_saturated  <= sat;
      end
   end

endmodule

>>> hw/rtl/multi_mode_activation_unit.sv
// Top level of the multi-mode activation unit: mode register and datapath.
// Each transaction carries one signed fixed-point sample and yields one activated sample,
// with a new sample accepted every cycle while the output is not stalled; the input
// register takes the sample at the accepting edge, and the three stages behind it (operand
// prep, constant and table multiplies, round and clamp) carry it to the output. A stalled
// output backs up only as far as the stages are full.
// The mode register sits at byte address 0 of the APB port and should be written only
// while no transaction is in flight; ramp is the only mode that can clamp and flag.
module multi_mode_activation_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample_out,
   output logic               rsp_saturated
);
   import mmau_pkg::*;

   mode_type mode_ff;
   logic     reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = 32'(csr_paddr[2]) == REG_MODE;

   // Mode register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         mode_ff <= mode_type'(csr_pwdata[2:0]);
      end
   end

   // Register read-back.
   assign csr_prdata = reg_hit ? {29'd0, mode_ff} : 32'd0;

   mmau_pipe #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_pipe (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .rsp_saturated (rsp_saturated)
   );

endmodule

>>> hw/rtl/mmau_chk.sv
// Port-level checker for the activation unit and its bind.
module mmau_chk #(
   parameter int DATA_WIDTH = 32
) (
   input logic               clock,
   input logic               reset,
   input logic               csr_pready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_sample_out,
   input logic               rsp_saturated
);
   localparam logic signed [DATA_WIDTH-1:0] HI = DATA_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [DATA_WIDTH-1:0] LO = DATA_WIDTH'(64'd1 << (DATA_WIDTH - 1));
   localparam logic [31:0] HI32 = 32'(HI);
   localparam logic [31:0] LO32 = 32'(LO);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The register port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready dropped");

   // A stalled result transaction holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_saturated))
      else $error("stalled result changed");

   // A flagged result is one of the range limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_sample_out == HI32) || (rsp_sample_out == LO32))
      else $error("saturated result not at a limit");

endmodule

bind multi_mode_activation_unit mmau_chk #(.DATA_WIDTH(DATA_WIDTH)) u_mmau_chk (
   .clock         (clock),
   .reset         (reset),
   .csr_pready    (csr_pready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_sample_out(rsp_sample_out),
   .rsp_saturated (rsp_saturated)
);
